@@ rtl/core/vpc_pkg.sv @@
`timescale 1ns / 1ps
package vpc_pkg;

  localparam int COORD_W    = 24;
  localparam int EXT_W      = 23;
  localparam int FRAME_W    = 13;
  localparam int PIX_W      = 16;
  localparam int COLOR_W    = 24;
  localparam int CMD_W      = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  // Translated coordinates in half-LSB units and their scaled magnitudes.
  localparam int TR_W       = 28;
  localparam int PROD_W     = TR_W + FRAME_W;
  localparam int QUO_BITS   = PIX_W - 1;
  localparam int DIVR_W     = EXT_W + 1;
  localparam int LANES      = 4;

  localparam int MAX_FRAME_DIM_DEF = 4096;
  localparam int QUEUE_DEPTH_DEF   = 4;

  localparam logic [CMD_W-1:0] CMD_LINE   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RECT   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CIRCLE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_SPARE  = 2'd3;

  localparam logic KIND_RECT   = 1'b0;
  localparam logic KIND_CIRCLE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VIEW_W   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_VIEW_H   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_W  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_H  = 3'd5;

  localparam logic [EXT_W-1:0]   RST_VIEW_W  = 23'd163840;
  localparam logic [EXT_W-1:0]   RST_VIEW_H  = 23'd122880;
  localparam logic [FRAME_W-1:0] RST_FRAME_W = 13'd640;
  localparam logic [FRAME_W-1:0] RST_FRAME_H = 13'd480;

  typedef struct packed {
    logic [CMD_W-1:0]          command;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic [EXT_W-1:0]          extent_a;
    logic [EXT_W-1:0]          extent_b;
    logic [COLOR_W-1:0]        fill_color;
  } item_t;

  typedef struct packed {
    logic                    shape_kind;
    logic signed [PIX_W-1:0] pix_a;
    logic signed [PIX_W-1:0] pix_b;
    logic signed [PIX_W-1:0] pix_c;
    logic signed [PIX_W-1:0] pix_d;
    logic [COLOR_W-1:0]      out_color;
  } result_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] offset_x;
    logic signed [COORD_W-1:0] offset_y;
    logic [EXT_W-1:0]          view_w;
    logic [EXT_W-1:0]          view_h;
    logic [FRAME_W-1:0]        frame_w;
    logic [FRAME_W-1:0]        frame_h;
    logic                      view_zero;
    logic                      busy;
  } view_cfg_t;

  typedef struct packed {
    logic                   kind;
    logic signed [TR_W-1:0] a;
    logic signed [TR_W-1:0] b;
    logic signed [TR_W-1:0] c;
    logic signed [TR_W-1:0] d;
    logic [COLOR_W-1:0]     color;
  } entry_t;

endpackage

@@ rtl/core/vpc_setup.sv @@
`timescale 1ns / 1ps
module vpc_setup #(
  parameter int MAX_FRAME_DIM = vpc_pkg::MAX_FRAME_DIM_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [vpc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [vpc_pkg::CFG_DATA_W-1:0]  cfg_data,
  output vpc_pkg::view_cfg_t              view
);
  import vpc_pkg::*;

  localparam int NUM_W = EXT_W + FRAME_W;
  localparam int CNT_W = $clog2(NUM_W + 1);

  typedef enum logic [1:0] {S_IDLE, S_LOAD, S_DIV} state_t;

  state_t                    state;
  logic signed [COORD_W-1:0] off_x, off_y;
  logic [EXT_W-1:0]          box_w, box_h;
  logic [FRAME_W-1:0]        frm_w, frm_h;
  logic [FRAME_W-1:0]        fw_c, fh_c, fw_sat, fh_sat;
  logic [EXT_W-1:0]          eff_w, eff_h;
  logic                      wider;
  logic [NUM_W-1:0]          num;
  logic [FRAME_W-1:0]        den;
  logic [FRAME_W-1:0]        rem;
  logic [FRAME_W:0]          rem_t;
  logic                      take;
  logic [CNT_W-1:0]          cnt;

  assign fw_sat = (32'(frm_w) > MAX_FRAME_DIM) ? FRAME_W'(MAX_FRAME_DIM) : frm_w;
  assign fh_sat = (32'(frm_h) > MAX_FRAME_DIM) ? FRAME_W'(MAX_FRAME_DIM) : frm_h;
  assign rem_t  = {rem, num[NUM_W-1]};
  assign take   = rem_t >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      off_x <= '0;
      off_y <= '0;
      box_w <= RST_VIEW_W;
      box_h <= RST_VIEW_H;
      frm_w <= RST_FRAME_W;
      frm_h <= RST_FRAME_H;
      eff_w <= RST_VIEW_W;
      eff_h <= RST_VIEW_H;
      cnt   <= '0;
    end else if (cfg_write) begin
      state <= S_LOAD;
      unique case (cfg_index)
        CFG_OFFSET_X: off_x <= cfg_data;
        CFG_OFFSET_Y: off_y <= cfg_data;
        CFG_VIEW_W:   box_w <= cfg_data[EXT_W-1:0];
        CFG_VIEW_H:   box_h <= cfg_data[EXT_W-1:0];
        CFG_FRAME_W:  frm_w <= cfg_data[FRAME_W-1:0];
        CFG_FRAME_H:  frm_h <= cfg_data[FRAME_W-1:0];
        default: ;
      endcase
    end else begin
      unique case (state)
        S_IDLE: ;
        S_LOAD: begin
          fw_c  <= fw_sat;
          fh_c  <= fh_sat;
          wider <= fw_sat > fh_sat;
          rem   <= '0;
          cnt   <= CNT_W'(NUM_W);
          if (fw_sat > fh_sat) begin
            num   <= NUM_W'(box_w) * NUM_W'(fh_sat);
            den   <= fw_sat;
            state <= S_DIV;
          end else if (fh_sat != '0) begin
            num   <= NUM_W'(box_h) * NUM_W'(fw_sat);
            den   <= fh_sat;
            state <= S_DIV;
          end else begin
            eff_w <= '0;
            eff_h <= box_h;
            state <= S_IDLE;
          end
        end
        S_DIV: begin
          if (cnt == '0) begin
            eff_w <= wider ? box_w : num[EXT_W-1:0];
            eff_h <= wider ? num[EXT_W-1:0] : box_h;
            state <= S_IDLE;
          end else begin
            rem <= take ? FRAME_W'(rem_t - {1'b0, den}) : rem_t[FRAME_W-1:0];
            num <= {num[NUM_W-2:0], take};
            cnt <= cnt - 1'b1;
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  always_comb begin
    view.offset_x  = off_x;
    view.offset_y  = off_y;
    view.view_w    = eff_w;
    view.view_h    = eff_h;
    view.frame_w   = fw_c;
    view.frame_h   = fh_c;
    view.view_zero = (eff_w == '0) || (eff_h == '0);
    view.busy      = state != S_IDLE;
  end

endmodule

@@ rtl/core/vpc_front.sv @@
`timescale 1ns / 1ps
module vpc_front (
  input  vpc_pkg::item_t     item,
  input  vpc_pkg::view_cfg_t view,
  output logic               keep,
  output vpc_pkg::entry_t    entry
);
  import vpc_pkg::*;

  logic signed [TR_W-1:0] px, py, ox, oy, ea, eb, vw, vh, vw2, vh2;
  logic signed [TR_W-1:0] x1, y1, x2, y2, x1c, y1c, x2c, y2c, r2;
  logic                   rect_keep, circ_keep;

  always_comb begin
    px  = TR_W'(item.pos_x);
    py  = TR_W'(item.pos_y);
    ox  = TR_W'(view.offset_x);
    oy  = TR_W'(view.offset_y);
    ea  = signed'(TR_W'(item.extent_a));
    eb  = signed'(TR_W'(item.extent_b));
    vw  = signed'(TR_W'(view.view_w));
    vh  = signed'(TR_W'(view.view_h));
    vw2 = vw <<< 1;
    vh2 = vh <<< 1;
    x1  = (px <<< 1) + (ox <<< 1) + vw;
    y1  = (py <<< 1) + (oy <<< 1) + vh;
    x2  = ((px + ea) <<< 1) + (ox <<< 1) + vw;
    y2  = ((py + eb) <<< 1) + (oy <<< 1) + vh;
    r2  = ea <<< 1;
    x1c = (x1 < 0) ? '0 : x1;
    y1c = (y1 < 0) ? '0 : y1;
    x2c = (x2 > vw2) ? vw2 : x2;
    y2c = (y2 > vh2) ? vh2 : y2;
    rect_keep = (x1c < x2c) && (y1c < y2c);
    circ_keep = !((x1 + r2 < 0) || (y1 + r2 < 0) || (x1 - r2 > vw2) || (y1 - r2 > vh2));

    entry.color = item.fill_color;
    if (item.command == CMD_CIRCLE) begin
      entry.kind = KIND_CIRCLE;
      entry.a    = x1;
      entry.b    = y1;
      entry.c    = r2;
      entry.d    = '0;
      keep       = circ_keep && !view.view_zero;
    end else begin
      entry.kind = KIND_RECT;
      entry.a    = x1c;
      entry.b    = y1c;
      entry.c    = x2c;
      entry.d    = y2c;
      keep       = (item.command == CMD_RECT) && rect_keep && !view.view_zero;
    end
  end

endmodule

@@ rtl/core/vpc_queue.sv @@
`timescale 1ns / 1ps
module vpc_queue #(
  parameter int DEPTH = vpc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  vpc_pkg::entry_t push_data,
  output logic            full,
  input  logic            pop,
  output vpc_pkg::entry_t pop_data,
  output logic            empty
);
  import vpc_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  entry_t           slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = count == CNT_W'(DEPTH);
  assign empty    = count == '0;
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

@@ rtl/core/vpc_back.sv @@
`timescale 1ns / 1ps
module vpc_back (
  input  logic               clk,
  input  logic               rst,
  input  vpc_pkg::view_cfg_t view,
  input  logic               q_empty,
  input  vpc_pkg::entry_t    q_data,
  output logic               q_pop,
  output logic               result_valid,
  input  logic               result_stall,
  output vpc_pkg::result_t   result
);
  import vpc_pkg::*;

  localparam int NST = QUO_BITS;

  logic                   en;
  logic                   v0;
  entry_t                 e0;
  logic signed [TR_W-1:0] lane_in [LANES];
  logic [TR_W-1:0]        mag_in  [LANES];
  logic [FRAME_W-1:0]     frm     [LANES];
  logic [DIVR_W-1:0]      dvr     [LANES];

  logic                   v1, k1;
  logic [COLOR_W-1:0]     c1;
  logic [PROD_W-1:0]      mag1 [LANES];
  logic                   neg1 [LANES];

  logic                   dv_valid [NST];
  logic                   dv_kind  [NST];
  logic [COLOR_W-1:0]     dv_color [NST];
  logic [PROD_W-1:0]      dv_rem   [NST][LANES];
  logic [QUO_BITS-1:0]    dv_q     [NST][LANES];
  logic                   dv_sat   [NST][LANES];
  logic                   dv_neg   [NST][LANES];
  logic [PROD_W-1:0]      rem_next [NST][LANES];
  logic                   bit_next [NST][LANES];
  logic [PIX_W-1:0]       pix      [LANES];

  assign en    = !result_valid || !result_stall;
  assign q_pop = en && !q_empty;

  always_comb begin
    lane_in[0] = e0.a;
    lane_in[1] = e0.b;
    lane_in[2] = e0.c;
    lane_in[3] = e0.d;
    for (int l = 0; l < LANES; l++) begin
      mag_in[l] = lane_in[l][TR_W-1] ? TR_W'(-lane_in[l]) : TR_W'(lane_in[l]);
      frm[l]    = (l % 2 == 0) ? view.frame_w : view.frame_h;
      dvr[l]    = (l % 2 == 0) ? {view.view_w, 1'b0} : {view.view_h, 1'b0};
    end
  end

  always_comb begin
    for (int j = 0; j < NST; j++) begin
      for (int l = 0; l < LANES; l++) begin
        logic [PROD_W-1:0] src;
        logic [PROD_W-1:0] dsh;
        src = (j == 0) ? mag1[l] : dv_rem[(j == 0) ? 0 : j - 1][l];
        dsh = PROD_W'(dvr[l]) << (NST - 1 - j);
        bit_next[j][l] = src >= dsh;
        rem_next[j][l] = bit_next[j][l] ? src - dsh : src;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0           <= 1'b0;
      v1           <= 1'b0;
      result_valid <= 1'b0;
      for (int j = 0; j < NST; j++) begin
        dv_valid[j] <= 1'b0;
      end
    end else if (en) begin
      v0           <= q_pop;
      v1           <= v0;
      dv_valid[0]  <= v1;
      for (int j = 1; j < NST; j++) begin
        dv_valid[j] <= dv_valid[j-1];
      end
      result_valid <= dv_valid[NST-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e0 <= q_data;
      k1 <= e0.kind;
      c1 <= e0.color;
      for (int l = 0; l < LANES; l++) begin
        mag1[l] <= PROD_W'(mag_in[l]) * PROD_W'(frm[l]);
        neg1[l] <= lane_in[l][TR_W-1];
      end
      dv_kind[0]  <= k1;
      dv_color[0] <= c1;
      for (int l = 0; l < LANES; l++) begin
        dv_sat[0][l] <= mag1[l] >= (PROD_W'(dvr[l]) << QUO_BITS);
        dv_neg[0][l] <= neg1[l];
        dv_rem[0][l] <= rem_next[0][l];
        dv_q[0][l]   <= QUO_BITS'(bit_next[0][l]);
      end
      for (int j = 1; j < NST; j++) begin
        dv_kind[j]  <= dv_kind[j-1];
        dv_color[j] <= dv_color[j-1];
        for (int l = 0; l < LANES; l++) begin
          dv_sat[j][l] <= dv_sat[j-1][l];
          dv_neg[j][l] <= dv_neg[j-1][l];
          dv_rem[j][l] <= rem_next[j][l];
          dv_q[j][l]   <= {dv_q[j-1][l][QUO_BITS-2:0], bit_next[j][l]};
        end
      end
      result.shape_kind <= dv_kind[NST-1];
      result.out_color  <= dv_color[NST-1];
      result.pix_a      <= pix[0];
      result.pix_b      <= pix[1];
      result.pix_c      <= pix[2];
      result.pix_d      <= pix[3];
    end
  end

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      if (dv_sat[NST-1][l]) begin
        pix[l] = dv_neg[NST-1][l] ? {1'b1, {(PIX_W-1){1'b0}}} : {1'b0, {(PIX_W-1){1'b1}}};
      end else if (dv_neg[NST-1][l]) begin
        pix[l] = PIX_W'(-{1'b0, dv_q[NST-1][l]});
      end else begin
        pix[l] = {1'b0, dv_q[NST-1][l]};
      end
    end
  end

endmodule

@@ rtl/core/primitive_viewport_clip_scale.sv @@
`timescale 1ns / 1ps
// Channel   Signals                               Beat
// item      item_valid, item_stall, item          one primitive in
// result    result_valid, result_stall, result    one pixel-space shape out
// config    cfg_write, cfg_index, cfg_data        one register write
//
// One primitive is accepted per cycle while item_stall is low; a kept one goes
// through the queue and the one-bit-per-stage division pipeline in the back end.
// After reset and after every register write the view fit runs a serial
// divider unless both frame sizes are zero; item_stall is high until it ends.
// A queue (default four entries) parts the classifier from the scaling pipe,
// so a stalled result holds the back end; the front takes items till it fills.
module primitive_viewport_clip_scale #(
  parameter int MAX_FRAME_DIM = vpc_pkg::MAX_FRAME_DIM_DEF,
  parameter int QUEUE_DEPTH   = vpc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           item_valid,
  output logic                           item_stall,
  input  vpc_pkg::item_t                 item,
  output logic                           result_valid,
  input  logic                           result_stall,
  output vpc_pkg::result_t               result,
  input  logic                           cfg_write,
  input  logic [vpc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [vpc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import vpc_pkg::*;

  view_cfg_t view;
  entry_t    f_entry, q_data;
  logic      keep, q_full, q_empty, q_pop;

  assign item_stall = view.busy || q_full;

  vpc_setup #(.MAX_FRAME_DIM(MAX_FRAME_DIM)) u_setup (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .view      (view)
  );

  vpc_front u_front (
    .item  (item),
    .view  (view),
    .keep  (keep),
    .entry (f_entry)
  );

  vpc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (item_valid && !item_stall && keep),
    .push_data (f_entry),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_data),
    .empty     (q_empty)
  );

  vpc_back u_back (
    .clk          (clk),
    .rst          (rst),
    .view         (view),
    .q_empty      (q_empty),
    .q_data       (q_data),
    .q_pop        (q_pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  a_cfg_blocks: assert property (@(posedge clk) disable iff (rst)
    cfg_write |=> item_stall)
    else $error("item port open straight after a register write");

  a_rect_order: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.shape_kind == KIND_RECT |->
      result.pix_a >= 0 && result.pix_a <= result.pix_c &&
      result.pix_b >= 0 && result.pix_b <= result.pix_d)
    else $error("clipped rectangle corners out of order");

  a_circle_form: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.shape_kind == KIND_CIRCLE |->
      result.pix_d == 0 && result.pix_c >= 0)
    else $error("circle result malformed");

endmodule
